// ----- rtl/core/mlf_pkg.sv -----
// Shared types and constants for the MAC learning forwarder.
`timescale 1ns / 1ps

package mlf_pkg;

    localparam int MAC_W             = 48;
    localparam int PEER_ID_W         = 8;
    localparam int OUT_PEER_W        = 8;
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int PEER_BITS_DEF     = 8;

    localparam logic [7:0]       BYTE_ALL_ONES = 8'hff;
    localparam logic [MAC_W-1:0] MAC_BCAST     = {6{BYTE_ALL_ONES}};

    typedef enum logic [1:0] {
        ACT_DROP  = 2'd0,
        ACT_LOCAL = 2'd1,
        ACT_PEER  = 2'd2,
        ACT_FLOOD = 2'd3
    } t_action;

    typedef struct packed {
        t_action                 action;
        logic [OUT_PEER_W-1:0]   out_peer;
        logic                    learned;
        logic                    table_full;
    } t_result;

endpackage

// ----- rtl/core/mlf_table.sv -----
// Station table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module mlf_table import mlf_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int PEER_BITS     = PEER_BITS_DEF,
    localparam int AW = $clog2(TABLE_ENTRIES)
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [MAC_W-1:0]     o_rd_mac,
    output logic [PEER_BITS-1:0] o_rd_peer,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [MAC_W-1:0]     i_wr_mac,
    input  logic [PEER_BITS-1:0] i_wr_peer
);

    logic [MAC_W+PEER_BITS-1:0] r_mem [TABLE_ENTRIES];
    logic [MAC_W+PEER_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_mac, i_wr_peer};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_mac  = r_rd_data[MAC_W+PEER_BITS-1:PEER_BITS];
    assign o_rd_peer = r_rd_data[PEER_BITS-1:0];

endmodule

// ----- rtl/core/mlf_ctrl.sv -----
// Lookup sequencer: scans the filled part of the table, learns, builds results.
`timescale 1ns / 1ps

module mlf_ctrl import mlf_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int PEER_BITS     = PEER_BITS_DEF,
    localparam int AW = $clog2(TABLE_ENTRIES),
    localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic                 i_bridge_en,
    input  logic                 i_kind,
    input  logic [MAC_W-1:0]     i_dest_mac,
    input  logic [MAC_W-1:0]     i_src_mac,
    input  logic [PEER_ID_W-1:0] i_peer_id,
    output logic                 o_rd_en,
    output logic [AW-1:0]        o_rd_addr,
    input  logic [MAC_W-1:0]     i_rd_mac,
    input  logic [PEER_BITS-1:0] i_rd_peer,
    output logic                 o_wr_en,
    output logic [AW-1:0]        o_wr_addr,
    output logic [MAC_W-1:0]     o_wr_mac,
    output logic [PEER_BITS-1:0] o_wr_peer,
    output logic                 o_res_vld,
    output t_result              o_res
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state               r_state, n_state;
    logic                 r_kind, n_kind;
    logic [MAC_W-1:0]     r_key, n_key;
    logic [PEER_BITS-1:0] r_peer, n_peer;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_rd_vld, n_rd_vld;
    logic                 r_res_vld, n_res_vld;
    t_result              r_res, n_res;

    logic accept, match, more, room, scan_end, issue, learn;

    always_comb begin
        accept   = i_start && (r_state == ST_IDLE);
        match    = r_rd_vld && (i_rd_mac == r_key);
        more     = r_idx < r_count;
        room     = r_count < CW'(TABLE_ENTRIES);
        // once nothing is left to issue, the read in flight (if any) is the last one
        scan_end = (r_state == ST_SCAN) && (match || !more);
        issue    = (r_state == ST_SCAN) && more && !match;
        learn    = scan_end && !r_kind && !match && room;

        n_state   = r_state;
        n_kind    = r_kind;
        n_key     = r_key;
        n_peer    = r_peer;
        n_idx     = issue ? r_idx + 1'b1 : r_idx;
        n_count   = learn ? r_count + 1'b1 : r_count;
        n_rd_vld  = issue;
        n_res_vld = 1'b0;
        n_res     = r_res;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_kind = i_kind;
                    n_key  = i_kind ? i_dest_mac : i_src_mac;
                    n_peer = PEER_BITS'(i_peer_id);
                    n_idx  = '0;
                    n_res  = '{action: ACT_DROP, out_peer: '0,
                               learned: 1'b0, table_full: 1'b0};
                    if (!i_kind && !i_bridge_en) begin
                        n_res_vld = 1'b1;
                    end else if (i_kind && (i_dest_mac == MAC_BCAST)) begin
                        n_res.action = ACT_FLOOD;
                        n_res_vld    = 1'b1;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state   = ST_IDLE;
                    n_res_vld = 1'b1;
                    if (r_kind) begin
                        if (match) begin
                            n_res.action   = ACT_PEER;
                            n_res.out_peer = OUT_PEER_W'(i_rd_peer);
                        end
                    end else begin
                        n_res.action     = ACT_LOCAL;
                        n_res.learned    = !match && room;
                        n_res.table_full = !match && !room;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_key  <= n_key;
        r_peer <= n_peer;
        r_res  <= n_res;
    end

    assign o_busy    = (r_state != ST_IDLE);
    assign o_rd_en   = issue;
    assign o_rd_addr = r_idx[AW-1:0];
    assign o_wr_en   = learn;
    assign o_wr_addr = r_count[AW-1:0];
    assign o_wr_mac  = r_key;
    assign o_wr_peer = r_peer;
    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

    a_learn_xor_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> !(r_res.learned && r_res.table_full))
        else $error("learned and table_full both set");

    a_write_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        learn |-> (r_count < CW'(TABLE_ENTRIES)))
        else $error("table write with no free entry");

    a_write_bumps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        learn |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("fill count did not follow table write");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("fill count past table size");

endmodule

// ----- rtl/core/mac_learning_forwarder_top.sv -----
// Top level of the MAC learning forwarder: config register, sequencer, table.
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ---------------------------------------
//  item in   in         start && !busy         i_kind i_dest_mac i_src_mac i_peer_id
//  result    out        o_valid (1-cycle pulse) o_action o_out_peer o_learned o_table_full
//  config    in         i_cfg_wr_en            i_cfg_wr_data (bridge enable)
//
// Flow: a peer frame while the bridge is disabled, or a local broadcast, gives its
// result on the cycle after acceptance with busy staying low. Every other item scans the
// filled entries through the table's single read port, one entry per cycle, with busy
// high during the scan and the result on the cycle after the scan ends.
// Reset clears the fill count and control; entries beyond the count are never read,
// so no clearing pass is needed. Results cannot be stalled; one is shown per item.
`timescale 1ns / 1ps

module mac_learning_forwarder_top import mlf_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int PEER_BITS     = PEER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_kind,
    input  logic [MAC_W-1:0]      i_dest_mac,
    input  logic [MAC_W-1:0]      i_src_mac,
    input  logic [PEER_ID_W-1:0]  i_peer_id,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_wr_data,
    output logic                  o_valid,
    output logic [1:0]            o_action,
    output logic [OUT_PEER_W-1:0] o_out_peer,
    output logic                  o_learned,
    output logic                  o_table_full
);

    localparam int AW = $clog2(TABLE_ENTRIES);

    // bridge enable; the user must see that it is written only while idle, the block itself does not enforce this
    logic r_bridge_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bridge_en <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_bridge_en <= i_cfg_wr_data;
        end
    end

    logic                 rd_en, wr_en;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic [MAC_W-1:0]     rd_mac, wr_mac;
    logic [PEER_BITS-1:0] rd_peer, wr_peer;
    t_result              res;

    mlf_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PEER_BITS     (PEER_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_bridge_en (r_bridge_en),
        .i_kind      (i_kind),
        .i_dest_mac  (i_dest_mac),
        .i_src_mac   (i_src_mac),
        .i_peer_id   (i_peer_id),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_mac    (rd_mac),
        .i_rd_peer   (rd_peer),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_mac    (wr_mac),
        .o_wr_peer   (wr_peer),
        .o_res_vld   (o_valid),
        .o_res       (res)
    );

    mlf_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PEER_BITS     (PEER_BITS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_mac  (rd_mac),
        .o_rd_peer (rd_peer),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_mac  (wr_mac),
        .i_wr_peer (wr_peer)
    );

    assign o_action     = res.action;
    assign o_out_peer   = res.out_peer;
    assign o_learned    = res.learned;
    assign o_table_full = res.table_full;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the MAC learning forwarder: directed and random header traffic.
`timescale 1ns / 1ps

module tb_top;
    import mlf_pkg::*;

    // Block is built with its defaults; the table model below follows the same sizes.
    localparam int TBL_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int PEER_BITS   = PEER_BITS_DEF;
    localparam logic [15:0] PEER_MASK = 16'((32'd1 << PEER_BITS) - 1);

    // Cycles without any accepted item or result before the run is abandoned.
    // Worst legitimate stretch: longest sender gap + full 256-entry scan + result.
    localparam int WATCHDOG_LIMIT = 4000;

    // Fixed addresses used by the directed tests.
    localparam logic [MAC_W-1:0] MAC_ZERO = '0;
    localparam logic [MAC_W-1:0] MAC_ONE  = 48'h0000_0000_0001;
    localparam logic [MAC_W-1:0] MAC_A    = 48'h0200_5e10_0001;
    localparam logic [MAC_W-1:0] MAC_B    = 48'h0aa5_5aa5_5a0b;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_kind;
    logic [MAC_W-1:0]      i_dest_mac;
    logic [MAC_W-1:0]      i_src_mac;
    logic [PEER_ID_W-1:0]  i_peer_id;
    logic                  i_cfg_wr_en;
    logic                  i_cfg_wr_data;
    logic                  o_valid;
    logic [1:0]            o_action;
    logic [OUT_PEER_W-1:0] o_out_peer;
    logic                  o_learned;
    logic                  o_table_full;

    mac_learning_forwarder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_dest_mac    (i_dest_mac),
        .i_src_mac     (i_src_mac),
        .i_peer_id     (i_peer_id),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_valid       (o_valid),
        .o_action      (o_action),
        .o_out_peer    (o_out_peer),
        .o_learned     (o_learned),
        .o_table_full  (o_table_full)
    );

    // ------------------------------------------------------------------
    // Bridge table model: our own copy of the register and the entries.
    // Entries fill in index order, so fill_cnt is also the next free slot.
    // ------------------------------------------------------------------
    bit               bridge_on;
    bit               tbl_valid [TBL_ENTRIES];
    logic [MAC_W-1:0] tbl_mac   [TBL_ENTRIES];
    logic [15:0]      tbl_peer  [TBL_ENTRIES];
    int unsigned      fill_cnt;

    t_result          verdict_q [$];   // forwarding verdicts still owed by the block
    logic [MAC_W-1:0] src_pool  [$];   // sources seen on peer frames, reused for hits
    int               err_cnt;
    int               hdr_cnt;
    bit               burst_mode;      // back-to-back items, no sender gaps

    function automatic int find_mac(input logic [MAC_W-1:0] mac);
        for (int i = 0; i < TBL_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_mac[i] == mac) return i;
        end
        return -1;
    endfunction

    // Computes the verdict for one header and applies learning to the model.
    function automatic t_result forward_decision(input logic kind,
                                                 input logic [MAC_W-1:0] dest,
                                                 input logic [MAC_W-1:0] src,
                                                 input logic [PEER_ID_W-1:0] peer);
        t_result r;
        int      idx;
        r.action     = ACT_DROP;
        r.out_peer   = '0;
        r.learned    = 1'b0;
        r.table_full = 1'b0;
        if (kind == 1'b0) begin
            // Peer frame: if the bridge is on, learn the source once, then hand to the local port.
            if (bridge_on) begin
                if (find_mac(src) < 0) begin
                    if (fill_cnt < TBL_ENTRIES) begin
                        tbl_valid[fill_cnt] = 1'b1;
                        tbl_mac[fill_cnt]   = src;
                        tbl_peer[fill_cnt]  = 16'(peer) & PEER_MASK;
                        fill_cnt++;
                        r.learned = 1'b1;
                    end else begin
                        r.table_full = 1'b1;
                    end
                end
                r.action = ACT_LOCAL;
            end
        end else begin
            // Local frame: broadcast floods even if all-ones was learned as a source.
            if (dest == MAC_BCAST) begin
                r.action = ACT_FLOOD;
            end else begin
                idx = find_mac(dest);
                if (idx >= 0) begin
                    r.action   = ACT_PEER;
                    r.out_peer = tbl_peer[idx][OUT_PEER_W-1:0];
                end
            end
        end
        return r;
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[MAC_W-1:0];
    endfunction

    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, 13);
    endfunction

    // ------------------------------------------------------------------
    // Clock, watchdog, result checker
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    int idle_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d verdicts outstanding", $time,
                     verdict_q.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Each result pulse is matched against the oldest outstanding verdict.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: result with nothing pending: action %0d peer %0d",
                         $time, o_action, o_out_peer);
                err_cnt++;
            end else begin
                want = verdict_q.pop_front();
                if (o_action !== want.action) begin
                    $display("%0t: action exp %0d got %0d", $time, want.action, o_action);
                    err_cnt++;
                end
                if (o_out_peer !== want.out_peer) begin
                    $display("%0t: out_peer exp %0d got %0d", $time, want.out_peer,
                             o_out_peer);
                    err_cnt++;
                end
                if (o_learned !== want.learned) begin
                    $display("%0t: learned exp %0b got %0b", $time, want.learned,
                             o_learned);
                    err_cnt++;
                end
                if (o_table_full !== want.table_full) begin
                    $display("%0t: table_full exp %0b got %0b", $time, want.table_full,
                             o_table_full);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Inputs change on the falling edge; acceptance is judged on
    // the rising edge from the pre-edge value of busy.
    // ------------------------------------------------------------------
    task automatic send_header(input logic kind, input logic [MAC_W-1:0] dest,
                               input logic [MAC_W-1:0] src,
                               input logic [PEER_ID_W-1:0] peer);
        int gap;
        gap = draw_gap();
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start      = 1'b1;
        i_kind     = kind;
        i_dest_mac = dest;
        i_src_mac  = src;
        i_peer_id  = peer;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // Accepted at this edge; start stays high until the next drive decides.
        verdict_q.push_back(forward_decision(kind, dest, src, peer));
        if (kind == 1'b0) src_pool.push_back(src);
        hdr_cnt++;
    endtask

    // Drop start and let every outstanding verdict come back.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register writes only happen with the block idle.
    task automatic write_bridge_enable(input bit en);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = en;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        bridge_on     = en;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register still at its reset value: peer frames are dropped unlearned,
    // local frames are still handled normally.
    task automatic test_bridge_disabled();
        send_header(1'b0, rand_mac(), MAC_A, 8'd3);
        send_header(1'b0, MAC_BCAST, MAC_BCAST, 8'hff);
        send_header(1'b1, MAC_BCAST, MAC_ZERO, 8'h00);
        send_header(1'b1, MAC_A, rand_mac(), 8'd3);
        write_bridge_enable(1'b0);
        send_header(1'b0, MAC_ZERO, MAC_ZERO, 8'h00);
    endtask

    // Learning, known-source rule and the three local verdicts on a near-empty table.
    task automatic test_learn_and_forward();
        write_bridge_enable(1'b1);
        send_header(1'b0, MAC_ZERO, MAC_A, 8'h00);
        // All-ones source is an ordinary address; broadcast dest from a peer goes local.
        send_header(1'b0, MAC_BCAST, MAC_BCAST, 8'hff);
        send_header(1'b0, rand_mac(), MAC_ZERO, 8'h5a);
        // Known source from another peer: stored peer must not change.
        send_header(1'b0, rand_mac(), MAC_A, 8'd77);
        send_header(1'b1, MAC_A, rand_mac(), 8'hff);
        send_header(1'b1, MAC_ZERO, MAC_BCAST, 8'h00);
        send_header(1'b1, MAC_BCAST, MAC_A, 8'h12);
        send_header(1'b1, MAC_ONE, MAC_ZERO, 8'h00);
        send_header(1'b1, MAC_B, MAC_ZERO, 8'h00);
    endtask

    // Turning the bridge off stops learning but keeps existing entries usable.
    task automatic test_disable_midway();
        write_bridge_enable(1'b0);
        send_header(1'b0, MAC_A, MAC_B, 8'd9);
        send_header(1'b1, MAC_B, MAC_A, 8'd0);
        send_header(1'b1, MAC_A, MAC_B, 8'd0);
        write_bridge_enable(1'b1);
        send_header(1'b0, MAC_A, MAC_B, 8'd9);
        send_header(1'b1, MAC_B, MAC_A, 8'd0);
    endtask

    // Mixed traffic. new_pct sets how often a peer frame brings a fresh source.
    // Local frames mostly target sources already seen on peer frames so the forward path is exercised.
    task automatic random_traffic(input int n, input int new_pct);
        logic [MAC_W-1:0] dest;
        logic [MAC_W-1:0] src;
        int               pick;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 39) == 0) burst_mode = ~burst_mode;
            // Occasional bridge toggles; spend most of the time enabled.
            if (bridge_on && $urandom_range(0, 119) == 0) write_bridge_enable(1'b0);
            else if (!bridge_on && $urandom_range(0, 14) == 0) write_bridge_enable(1'b1);
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 55) begin
                if (src_pool.size() == 0 || $urandom_range(0, 99) < new_pct)
                    src = rand_mac();
                else
                    src = src_pool[$urandom_range(0, src_pool.size() - 1)];
                dest = (pick < 10) ? MAC_BCAST : rand_mac();
                send_header(1'b0, dest, src, 8'($urandom_range(0, 255)));
            end else begin
                if (pick < 15)
                    dest = MAC_BCAST;
                else if (pick < 70 && src_pool.size() != 0)
                    dest = src_pool[$urandom_range(0, src_pool.size() - 1)];
                else
                    dest = rand_mac();
                send_header(1'b1, dest, rand_mac(), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Fill every slot, then overflow: new sources flag table_full and are still
    // delivered locally, known sources do not, first and last slots still forward.
    task automatic test_table_full();
        if (!bridge_on) write_bridge_enable(1'b1);
        while (fill_cnt < TBL_ENTRIES)
            send_header(1'b0, rand_mac(), rand_mac(), 8'($urandom_range(0, 255)));
        send_header(1'b0, rand_mac(), rand_mac(), 8'hff);
        send_header(1'b0, MAC_BCAST, rand_mac(), 8'h00);
        send_header(1'b0, rand_mac(), tbl_mac[TBL_ENTRIES-1], 8'h01);
        send_header(1'b1, tbl_mac[0], rand_mac(), 8'h00);
        send_header(1'b1, tbl_mac[TBL_ENTRIES-1], rand_mac(), 8'h00);
        send_header(1'b1, rand_mac(), rand_mac(), 8'h00);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        start         = 1'b0;
        i_kind        = 1'b0;
        i_dest_mac    = '0;
        i_src_mac     = '0;
        i_peer_id     = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
        i_rst_n       = 1'b0;
        bridge_on     = 1'b0;
        fill_cnt      = 0;
        err_cnt       = 0;
        hdr_cnt       = 0;
        burst_mode    = 1'b0;
        for (int i = 0; i < TBL_ENTRIES; i++) tbl_valid[i] = 1'b0;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_bridge_disabled();
        test_learn_and_forward();
        test_disable_midway();
        random_traffic(300, 60);
        test_table_full();
        random_traffic(170, 40);
        // Last stretch starting with the bridge off over a full table.
        write_bridge_enable(1'b0);
        random_traffic(10, 50);

        drain();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
